// ===== hw/rtl/k_way_merge_selector_unit_assert.svh =====
// ----------------------------------------------------------------------------
// k_way_merge_selector_unit assertion macros
// Shared concurrent assertion forms for the merge selector checkers.
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_SELECTOR_UNIT_ASSERT_SVH
`define K_WAY_MERGE_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define KWMS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define KWMS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kwms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwms_pkg
// Types and fixed field widths of the k-way merge selector.
// ----------------------------------------------------------------------------
package kwms_pkg;

    localparam int TAG_BITS = 27;
    localparam int WAY_BITS = 4;
    localparam int CFG_BITS = 5;

    // Item kinds carried on tuser.
    localparam logic OP_HEAD = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD
    } state_t;

endpackage

// ===== hw/rtl/kwms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kwms_ram #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/k_way_merge_selector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_merge_selector_unit
// Merge step of a balanced multiway sort over descending-sorted runs.
// ----------------------------------------------------------------------------
// Each item either delivers the head record of a way or ends the run on that
// way. An item that leaves some live way without a head gives no result. An
// item that completes the head set starts a scan of the head RAM, one way per
// cycle through its single read port. Such an item is accepted, the live
// ways are scanned and the result is loaded into the output register, which
// waits while an earlier result is unaccepted, before the next item is taken.
// The result then sits in the output register while the next item is accepted.
// When every active way has ended its run, an output item with tlast set marks
// the end of the merged run and all active ways take part again. Equal keys
// go to the lowest way. Writing active_ways starts a fresh round.
// ----------------------------------------------------------------------------
module k_way_merge_selector_unit #(
    parameter int MAX_WAYS = 16,
    parameter int KEY_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                           cfg_wen,
    input  logic [kwms_pkg::CFG_BITS-1:0]  cfg_wdata,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: way, in_key, in_tag, zero fill.
    input  logic [((kwms_pkg::WAY_BITS + KEY_BITS + kwms_pkg::TAG_BITS + 7) / 8) * 8 - 1:0]
                                           s_tdata,
    // Fields: opcode.
    input  logic                           s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: out_key, out_tag, out_way, zero fill.
    output logic [((kwms_pkg::WAY_BITS + KEY_BITS + kwms_pkg::TAG_BITS + 7) / 8) * 8 - 1:0]
                                           m_tdata,
    output logic                           m_tlast
);

    localparam int TAG_BITS = kwms_pkg::TAG_BITS;
    localparam int WAY_BITS = kwms_pkg::WAY_BITS;
    localparam int IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int CMP_W    = (CNT_W > kwms_pkg::CFG_BITS) ? CNT_W + 1 : kwms_pkg::CFG_BITS + 1;
    localparam int DATA_W   = ((WAY_BITS + KEY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int HEAD_W   = KEY_BITS + TAG_BITS;

    kwms_pkg::state_t state_reg, state_next;

    logic [kwms_pkg::CFG_BITS-1:0] active_ways_reg, active_ways_next;
    logic [MAX_WAYS-1:0]           valid_reg, valid_next;
    logic [MAX_WAYS-1:0]           retired_reg, retired_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          found_reg, found_next;
    logic                          end_reg, end_next;
    logic [KEY_BITS-1:0]           best_key_reg, best_key_next;
    logic [TAG_BITS-1:0]           best_tag_reg, best_tag_next;
    logic [IDX_W-1:0]              best_idx_reg, best_idx_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_last_reg, out_last_next;
    logic [KEY_BITS-1:0]           out_key_reg, out_key_next;
    logic [TAG_BITS-1:0]           out_tag_reg, out_tag_next;
    logic [WAY_BITS-1:0]           out_way_reg, out_way_next;

    // Input item fields.
    logic                 in_op;
    logic [WAY_BITS-1:0]  in_way;
    logic [KEY_BITS-1:0]  in_key;
    logic [TAG_BITS-1:0]  in_tag;
    logic [IDX_W-1:0]     in_idx;

    logic                 accept;
    logic [CNT_W-1:0]     live_n;
    logic [MAX_WAYS-1:0]  act_mask;
    logic [MAX_WAYS-1:0]  way_bit;
    logic [MAX_WAYS-1:0]  valid_upd;
    logic [MAX_WAYS-1:0]  retired_upd;
    logic [MAX_WAYS-1:0]  live_upd;
    logic [MAX_WAYS-1:0]  live_cur;
    logic                 way_ok;
    logic                 take;
    logic                 all_done;
    logic                 all_full;
    logic                 load_fire;

    // Scan datapath.
    logic [CNT_W-1:0]     prev_cnt;
    logic [IDX_W-1:0]     prev_idx;
    logic [HEAD_W-1:0]    ram_q;
    logic [KEY_BITS-1:0]  rd_key;
    logic [TAG_BITS-1:0]  rd_tag;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;

    assign in_op  = s_tuser;
    assign in_way = s_tdata[WAY_BITS-1:0];
    assign in_key = s_tdata[WAY_BITS +: KEY_BITS];
    assign in_tag = s_tdata[WAY_BITS + KEY_BITS +: TAG_BITS];
    assign in_idx = IDX_W'(in_way);

    assign accept = s_tvalid && s_tready;

    // An out-of-range way count acts as the nearest legal one.
    always_comb
    begin
        if (active_ways_reg == '0)
        begin
            live_n = CNT_W'(1);
        end
        else if (CMP_W'(active_ways_reg) > CMP_W'(MAX_WAYS))
        begin
            live_n = CNT_W'(MAX_WAYS);
        end
        else
        begin
            live_n = CNT_W'(active_ways_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            act_mask[i] = (CMP_W'(i) < CMP_W'(live_n));
        end
    end

    assign way_ok   = (CMP_W'(in_way) < CMP_W'(live_n));
    assign way_bit  = MAX_WAYS'(1) << in_idx;
    assign live_cur = act_mask & ~retired_reg;

    always_comb
    begin
        if (in_op == kwms_pkg::OP_HEAD)
        begin
            valid_upd   = valid_reg | way_bit;
            retired_upd = retired_reg;
            take        = way_ok && ((retired_reg & way_bit) == '0);
        end
        else
        begin
            valid_upd   = valid_reg & ~way_bit;
            retired_upd = retired_reg | way_bit;
            take        = way_ok;
        end
    end

    assign live_upd = act_mask & ~retired_upd;
    assign all_done = (live_upd == '0);
    assign all_full = ((valid_upd & live_upd) == live_upd);

    assign prev_cnt = cnt_reg - CNT_W'(1);
    assign prev_idx = prev_cnt[IDX_W-1:0];
    assign rd_key   = ram_q[KEY_BITS-1:0];
    assign rd_tag   = ram_q[KEY_BITS +: TAG_BITS];

    kwms_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (MAX_WAYS)
    ) u_head_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_idx),
        .wdata ({in_tag, in_key}),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kwms_pkg::ST_IDLE:
            begin
                if (accept && take && !cfg_wen)
                begin
                    if (all_done)
                    begin
                        state_next = kwms_pkg::ST_LOAD;
                    end
                    else if (all_full)
                    begin
                        state_next = kwms_pkg::ST_SCAN;
                    end
                end
            end
            kwms_pkg::ST_SCAN:
            begin
                if (cnt_reg == live_n)
                begin
                    state_next = kwms_pkg::ST_LOAD;
                end
            end
            kwms_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = kwms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kwms_pkg::ST_IDLE;
            end
        endcase
    end

    // State-decoded outputs.
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = cnt_reg[IDX_W-1:0];
        load_fire = 1'b0;
        case (state_reg)
            kwms_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                ram_we   = s_tvalid && take && (in_op == kwms_pkg::OP_HEAD) && !cfg_wen;
            end
            kwms_pkg::ST_SCAN:
            begin
                ram_raddr = cnt_reg[IDX_W-1:0];
            end
            kwms_pkg::ST_LOAD:
            begin
                load_fire = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Head bookkeeping, scan and result staging.
    always_comb
    begin
        active_ways_next = active_ways_reg;
        valid_next       = valid_reg;
        retired_next     = retired_reg;
        cnt_next         = cnt_reg;
        found_next       = found_reg;
        end_next         = end_reg;
        best_key_next    = best_key_reg;
        best_tag_next    = best_tag_reg;
        best_idx_next    = best_idx_reg;

        if (cfg_wen)
        begin
            active_ways_next = cfg_wdata;
            valid_next       = '0;
            retired_next     = '0;
        end
        else if (accept && take)
        begin
            cnt_next   = '0;
            found_next = 1'b0;
            end_next   = all_done;
            if (all_done)
            begin
                valid_next   = '0;
                retired_next = '0;
            end
            else
            begin
                valid_next   = valid_upd;
                retired_next = retired_upd;
            end
        end
        else if (state_reg == kwms_pkg::ST_SCAN)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            // The RAM word in hand belongs to the way addressed in the previous cycle.
            if (cnt_reg != '0 && live_cur[prev_idx] && (!found_reg || rd_key > best_key_reg))
            begin
                found_next    = 1'b1;
                best_key_next = rd_key;
                best_tag_next = rd_tag;
                best_idx_next = prev_idx;
            end
        end
        else if (load_fire && !end_reg)
        begin
            valid_next = valid_reg & ~(MAX_WAYS'(1) << best_idx_reg);
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_key_next   = out_key_reg;
        out_tag_next   = out_tag_reg;
        out_way_next   = out_way_reg;
        if (load_fire)
        begin
            out_valid_next = 1'b1;
            out_last_next  = end_reg;
            out_key_next   = end_reg ? '0 : best_key_reg;
            out_tag_next   = end_reg ? '0 : best_tag_reg;
            out_way_next   = end_reg ? '0 : WAY_BITS'(best_idx_reg);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= kwms_pkg::ST_IDLE;
            active_ways_reg <= kwms_pkg::CFG_BITS'(MAX_WAYS);
            valid_reg       <= '0;
            retired_reg     <= '0;
            cnt_reg         <= '0;
            found_reg       <= 1'b0;
            end_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            active_ways_reg <= active_ways_next;
            valid_reg       <= valid_next;
            retired_reg     <= retired_next;
            cnt_reg         <= cnt_next;
            found_reg       <= found_next;
            end_reg         <= end_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_key_reg <= best_key_next;
        best_tag_reg <= best_tag_next;
        best_idx_reg <= best_idx_next;
        out_last_reg <= out_last_next;
        out_key_reg  <= out_key_next;
        out_tag_reg  <= out_tag_next;
        out_way_reg  <= out_way_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = DATA_W'({out_way_reg, out_tag_reg, out_key_reg});

endmodule

// ===== hw/rtl/kwms_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwms_checker
// Port-level assertions for the k-way merge selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "k_way_merge_selector_unit_assert.svh"

module kwms_checker #(
    parameter int DATA_W = 48
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast
);

    // An end-of-run marker carries no record.
    `KWMS_ASSERT_IMP(a_end_payload_zero, m_tvalid && m_tlast, m_tdata == '0, "run end with data")

    // A fresh result is always loaded in a cycle where no item was taken.
    `KWMS_ASSERT_IMP(a_load_not_on_accept, $rose(m_tvalid), $past(!s_tready), "load beside accept")

    // A result that is not taken stays put.
    `KWMS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result moved")

endmodule

bind k_way_merge_selector_unit kwms_checker #(
    .DATA_W ($bits(m_tdata))
) u_kwms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
